// ----- src/mbnt_pkg.sv -----
// Shared constants and types for the missing-block NACK tracker.
`timescale 1ns / 1ps

package mbnt_pkg;

  localparam int MAX_BLOCKS  = 4096;
  localparam int BLOCK_BYTES = 1024;
  localparam int MAX_RANGES  = 32;

  localparam int BLK_W  = 12;  // block_number, range_first, range_last
  localparam int TOT_W  = 13;  // total_count
  localparam int OFS_W  = 22;  // write_offset
  localparam int KIND_W = 2;

  // received bitmap is kept as words of a RAM
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WORDS     = MAX_BLOCKS / WORD_BITS;
  localparam int WADDR_W   = $clog2(WORDS);

  localparam int IDX_W  = BLK_W + 1;               // scan index, may reach MAX_BLOCKS
  localparam int HS_W   = BLK_W + 1;               // signed highest-seen mark
  localparam int AT_W   = TOT_W + 1;               // signed announced total
  localparam int RCNT_W = $clog2(MAX_RANGES + 1);  // ranges started in a report

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK   = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_NONE  = 2'd3
  } mbnt_kind_e;

  typedef struct packed {
    logic              valid;
    mbnt_kind_e        kind;
    logic              newly;
    logic [OFS_W-1:0]  offset;
    logic [BLK_W-1:0]  first;
    logic [BLK_W-1:0]  last;
    logic              final_flag;
  } mbnt_res_t;

endpackage

// ----- src/missing_block_nack_tracker.sv -----
// Top level of the missing-block NACK tracker: sequencer, bitmap RAM, output stage.
`timescale 1ns / 1ps

// Receiver-side tracker for a block-numbered broadcast transfer. After reset
// the block clears its 4096-bit received bitmap (128 words of 32 bits), one word
// per cycle, so in_ready_o stays low until the clear is done. A data beat
// (command 0) reads one bitmap word on accept, then does the read-modify-write
// and issues one kind-0 result. A report beat (command 1) walks the bitmap one
// block per cycle, unless a full output register holds it, up to the highest
// block seen, plus one RAM read per 32-bit word; consecutive misses merge into
// one range and at most 32 ranges come out, the last with final_flag set.
// Results pass through a one-beat output register, and the sequencer holds
// whenever that register is still full.
module missing_block_nack_tracker import mbnt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [BLK_W-1:0]  block_number_i,
  input  logic [TOT_W-1:0]  total_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic              newly_received_o,
  output logic [OFS_W-1:0]  write_offset_o,
  output logic [BLK_W-1:0]  range_first_o,
  output logic [BLK_W-1:0]  range_last_o,
  output logic              final_flag_o
);

  mbnt_res_t              res;
  logic                   out_free;
  logic                   ram_we;
  logic [WADDR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [WADDR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  logic                   out_valid_q;
  mbnt_kind_e             kind_q;
  logic                   newly_q;
  logic [OFS_W-1:0]       offset_q;
  logic [BLK_W-1:0]       first_q;
  logic [BLK_W-1:0]       last_q;
  logic                   final_q;

  assign out_free = !out_valid_q || out_ready_i;

  mbnt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .block_number_i (block_number_i),
    .total_count_i  (total_count_i),
    .out_free_i     (out_free),
    .res_o          (res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  mbnt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // load a new beat only when the stage is free
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      kind_q   <= res.kind;
      newly_q  <= res.newly;
      offset_q <= res.offset;
      first_q  <= res.first;
      last_q   <= res.last;
      final_q  <= res.final_flag;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign newly_received_o = newly_q;
  assign write_offset_o   = offset_q;
  assign range_first_o    = first_q;
  assign range_last_o     = last_q;
  assign final_flag_o     = final_q;

endmodule

// ----- src/mbnt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbnt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mbnt_ctrl.sv -----
// Sequencer: bitmap clear, block update and bit-serial missing-range scan.
`timescale 1ns / 1ps

module mbnt_ctrl import mbnt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [BLK_W-1:0]     block_number_i,
  input  logic [TOT_W-1:0]     total_count_i,
  input  logic                 out_free_i,
  output mbnt_res_t            res_o,
  output logic                 ram_we_o,
  output logic [WADDR_W-1:0]   ram_waddr_o,
  output logic [WORD_BITS-1:0] ram_wdata_o,
  output logic                 ram_re_o,
  output logic [WADDR_W-1:0]   ram_raddr_o,
  input  logic [WORD_BITS-1:0] ram_rdata_i
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_UPD      = 3'd2;
  localparam logic [2:0] ST_SCAN_RD  = 3'd3;
  localparam logic [2:0] ST_SCAN_BIT = 3'd4;
  localparam logic [2:0] ST_END      = 3'd5;
  localparam logic [2:0] ST_TAIL     = 3'd6;
  localparam logic [2:0] ST_SPARE    = 3'd7;

  localparam logic signed [AT_W-1:0] LAST_BLK_S = AT_W'(MAX_BLOCKS - 1);
  localparam logic [RCNT_W-1:0]      RCNT_MAX   = RCNT_W'(MAX_RANGES);

  logic [2:0]              state_q, state_d;
  logic [WADDR_W-1:0]      clr_q, clr_d;
  logic [BLK_W-1:0]        blk_q, blk_d;
  logic [TOT_W-1:0]        tot_q, tot_d;
  logic signed [HS_W-1:0]  hs_q, hs_d;
  logic signed [AT_W-1:0]  at_q, at_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    pend_q, pend_d;
  logic [BLK_W-1:0]        pf_q, pf_d;
  logic [BLK_W-1:0]        pl_q, pl_d;
  logic [RCNT_W-1:0]       n_q, n_d;

  logic                    accept;
  logic signed [AT_W-1:0]  hs_x;
  logic signed [AT_W-1:0]  idx_x;
  logic signed [AT_W-1:0]  at_m1;
  logic signed [AT_W-1:0]  tail_f;
  logic signed [AT_W-1:0]  tail_l;
  logic                    past_end;
  logic                    tail_ok;
  logic                    cur_bit;
  logic                    upd_bit;
  logic [IDX_W-1:0]        idx_nxt;
  logic                    idx_wrap;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign hs_x     = {hs_q[HS_W-1], hs_q};
  assign idx_x    = {1'b0, idx_q};
  assign at_m1    = at_q - AT_W'(1);
  assign tail_f   = hs_x + AT_W'(1);
  assign tail_l   = (at_m1 > LAST_BLK_S) ? LAST_BLK_S : at_m1;
  assign past_end = idx_x > hs_x;
  assign tail_ok  = (n_q != RCNT_MAX) && (hs_x < at_m1) && (tail_f <= tail_l);

  assign cur_bit  = ram_rdata_i[idx_q[BIT_W-1:0]];
  assign upd_bit  = ram_rdata_i[blk_q[BIT_W-1:0]];
  assign idx_nxt  = idx_q + IDX_W'(1);
  assign idx_wrap = (idx_nxt[BIT_W-1:0] == '0);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    blk_d   = blk_q;
    tot_d   = tot_q;
    hs_d    = hs_q;
    at_d    = at_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    pf_d    = pf_q;
    pl_d    = pl_q;
    n_d     = n_q;

    res_o            = '0;
    res_o.kind       = KIND_ACK;
    res_o.final_flag = 1'b1;

    ram_we_o    = 1'b0;
    ram_waddr_o = clr_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[BLK_W-1:BIT_W];

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o = 1'b1;
        clr_d    = clr_q + WADDR_W'(1);
        if (clr_q == WADDR_W'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr_o = block_number_i[BLK_W-1:BIT_W];
        if (accept) begin
          blk_d = block_number_i;
          tot_d = total_count_i;
          if (command_i) begin
            idx_d   = '0;
            pend_d  = 1'b0;
            n_d     = '0;
            state_d = ST_SCAN_RD;
          end else begin
            ram_re_o = 1'b1;
            state_d  = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        ram_waddr_o = blk_q[BLK_W-1:BIT_W];
        ram_wdata_o = ram_rdata_i | (WORD_BITS'(1) << blk_q[BIT_W-1:0]);
        if (out_free_i) begin
          res_o.valid = 1'b1;
          if ($signed({1'b0, blk_q}) > hs_q) begin
            hs_d = {1'b0, blk_q};
          end
          if (!upd_bit) begin
            ram_we_o     = 1'b1;
            at_d         = {1'b0, tot_q};
            res_o.newly  = 1'b1;
            res_o.offset = OFS_W'(32'(blk_q) * 32'(BLOCK_BYTES));
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (past_end) begin
          state_d = ST_END;
        end else begin
          ram_re_o = 1'b1;
          state_d  = ST_SCAN_BIT;
        end
      end
      ST_SCAN_BIT: begin
        if (past_end) begin
          state_d = ST_END;
        end else if (cur_bit || (pend_q && (pl_q == idx_q[BLK_W-1:0] - BLK_W'(1)))) begin
          // received, or extends the open run
          if (!cur_bit) begin
            pl_d = idx_q[BLK_W-1:0];
          end
          idx_d = idx_nxt;
          if (idx_wrap) begin
            state_d = ST_SCAN_RD;
          end
        end else if (n_q == RCNT_MAX) begin
          // list full: the open run is the last one reported
          if (out_free_i) begin
            res_o.valid = 1'b1;
            res_o.kind  = KIND_RANGE;
            res_o.first = pf_q;
            res_o.last  = pl_q;
            state_d     = ST_IDLE;
          end
        end else if (!pend_q || out_free_i) begin
          if (pend_q) begin
            res_o.valid      = 1'b1;
            res_o.kind       = KIND_RANGE;
            res_o.first      = pf_q;
            res_o.last       = pl_q;
            res_o.final_flag = 1'b0;
          end
          pend_d = 1'b1;
          pf_d   = idx_q[BLK_W-1:0];
          pl_d   = idx_q[BLK_W-1:0];
          n_d    = n_q + RCNT_W'(1);
          idx_d  = idx_nxt;
          if (idx_wrap) begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_END: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          if (pend_q) begin
            res_o.kind       = KIND_RANGE;
            res_o.first      = pf_q;
            res_o.last       = pl_q;
            res_o.final_flag = !tail_ok;
            state_d          = tail_ok ? ST_TAIL : ST_IDLE;
          end else if (tail_ok) begin
            res_o.kind  = KIND_RANGE;
            res_o.first = tail_f[BLK_W-1:0];
            res_o.last  = tail_l[BLK_W-1:0];
            state_d     = ST_IDLE;
          end else begin
            res_o.kind = (hs_x == at_m1) ? KIND_DONE : KIND_NONE;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_RANGE;
          res_o.first = tail_f[BLK_W-1:0];
          res_o.last  = tail_l[BLK_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      ST_SPARE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      hs_q    <= '1;
      at_q    <= '1;
      pend_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hs_q    <= hs_d;
      at_q    <= at_d;
      pend_q  <= pend_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    tot_q <= tot_d;
    idx_q <= idx_d;
    pf_q  <= pf_d;
    pl_q  <= pl_d;
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("result issued while output stage busy");

  a_block_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !command_i) |=> (state_q == ST_UPD))
    else $error("block update did not follow accept");

  a_range_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RCNT_MAX)
    else $error("range count above limit");

  a_run_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && (state_q == ST_SCAN_BIT || state_q == ST_END)) |-> (pf_q <= pl_q))
    else $error("open run reversed");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the missing-block NACK tracker.
`timescale 1ns / 1ps

module testbench;
  import mbnt_pkg::*;

  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;
  localparam int   CYCLE_LIMIT = 10_000_000;
  localparam int   CALM_TAIL   = 40;   // last items go without idling
  localparam int   SETTLE      = 64;

  typedef struct {
    logic             cmd;
    logic [BLK_W-1:0] blk;
    logic [TOT_W-1:0] tot;
    bit               drain;   // hold this beat until every answer is back
  } beat_t;

  typedef struct packed {
    mbnt_kind_e        kind;
    logic              newly;
    logic [OFS_W-1:0]  offset;
    logic [BLK_W-1:0]  first;
    logic [BLK_W-1:0]  last;
    logic              fin;
  } answer_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              command_i      = 1'b0;
  logic [BLK_W-1:0]  block_number_i = '0;
  logic [TOT_W-1:0]  total_count_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic              newly_received_o;
  logic [OFS_W-1:0]  write_offset_o;
  logic [BLK_W-1:0]  range_first_o;
  logic [BLK_W-1:0]  range_last_o;
  logic              final_flag_o;

  missing_block_nack_tracker DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .block_number_i   (block_number_i),
    .total_count_i    (total_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .newly_received_o (newly_received_o),
    .write_offset_o   (write_offset_o),
    .range_first_o    (range_first_o),
    .range_last_o     (range_last_o),
    .final_flag_o     (final_flag_o)
  );

  // tracker mirror
  bit      got_map [MAX_BLOCKS];
  int      top_seen    = -1;
  int      total_known = -1;

  beat_t   pending_q[$];
  answer_t answer_q[$];
  bit      beat_taken  = 1'b0;
  int      gap_left    = 0;
  int      stall_left  = 0;
  int      fail_count  = 0;
  int      cycle_count = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic queue_beat(input logic cmd, input int blk, input int tot, input bit drain);
    pending_q.push_back('{cmd, BLK_W'(blk), TOT_W'(tot), drain});
  endtask

  task automatic predict_answers(input logic cmd, input logic [BLK_W-1:0] blk,
                                 input logic [TOT_W-1:0] tot);
    int  i;
    int  n;
    int  k;
    int  tail_first;
    int  tail_last;
    bit  holes;
    bit  full;
    int  firsts [MAX_RANGES];
    int  lasts  [MAX_RANGES];
    logic [OFS_W-1:0] ofs;
    if (cmd == CMD_DATA) begin
      if (int'(blk) > top_seen) top_seen = int'(blk);
      if (!got_map[blk]) begin
        got_map[blk] = 1'b1;
        total_known  = int'(tot);
        ofs          = OFS_W'(int'(blk) * BLOCK_BYTES);
        answer_q.push_back('{KIND_ACK, 1'b1, ofs, '0, '0, 1'b1});
      end else begin
        answer_q.push_back('{KIND_ACK, 1'b0, '0, '0, '0, 1'b1});
      end
    end else begin
      holes = 1'b0;
      for (i = 0; i <= top_seen && i < MAX_BLOCKS; i++)
        if (!got_map[i]) holes = 1'b1;
      if (!holes && top_seen == total_known - 1) begin
        answer_q.push_back('{KIND_DONE, 1'b0, '0, '0, '0, 1'b1});
      end else begin
        n    = 0;
        full = 1'b0;
        // ascending scan, merge adjacent misses
        for (i = 0; i <= top_seen && i < MAX_BLOCKS; i++) begin
          if (!got_map[i]) begin
            if (n > 0 && lasts[n-1] == i - 1) begin
              lasts[n-1] = i;
            end else if (n == MAX_RANGES) begin
              full = 1'b1;
              break;
            end else begin
              firsts[n] = i;
              lasts[n]  = i;
              n++;
            end
          end
        end
        if (!full && n < MAX_RANGES && top_seen < total_known - 1) begin
          tail_first = top_seen + 1;
          tail_last  = total_known - 1;
          if (tail_last > MAX_BLOCKS - 1) tail_last = MAX_BLOCKS - 1;
          if (tail_first <= tail_last) begin
            firsts[n] = tail_first;
            lasts[n]  = tail_last;
            n++;
          end
        end
        if (n == 0) begin
          answer_q.push_back('{KIND_NONE, 1'b0, '0, '0, '0, 1'b1});
        end else begin
          for (k = 0; k < n; k++)
            answer_q.push_back('{KIND_RANGE, 1'b0, '0, BLK_W'(firsts[k]),
                                 BLK_W'(lasts[k]), k == n - 1});
        end
      end
    end
  endtask

  // sender: record accepted beats
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_answers(command_i, block_number_i, total_count_i);
      beat_taken = 1'b1;
    end
  end

  // sender: present the next beat
  always @(negedge clk_i) begin
    beat_t nxt;
    if (rst_ni && !(in_valid_i && !beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_q[0].drain && answer_q.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_q.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
        gap_left   = $urandom_range(0, 10);
        in_valid_i <= 1'b0;
      end else begin
        nxt            = pending_q.pop_front();
        in_valid_i     <= 1'b1;
        command_i      <= nxt.cmd;
        block_number_i <= nxt.blk;
        total_count_i  <= nxt.tot;
      end
    end
  end

  // receiver: random back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (pending_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // receiver: check each result beat against the oldest answer
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{mbnt_kind_e'(kind_o), newly_received_o, write_offset_o,
              range_first_o, range_last_o, final_flag_o};
      if (answer_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t: unexpected result kind %0d newly %0d ofs %0d range %0d..%0d fin %0d",
                   $time, got.kind, got.newly, got.offset, got.first, got.last, got.fin);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 40) begin
            $display("%0t: mismatch expected kind %0d newly %0d ofs %0d range %0d..%0d fin %0d",
                     $time, want.kind, want.newly, want.offset, want.first, want.last,
                     want.fin);
            $display("%0t:          actual   kind %0d newly %0d ofs %0d range %0d..%0d fin %0d",
                     $time, got.kind, got.newly, got.offset, got.first, got.last, got.fin);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int  base;
    int  w;
    int  room;
    int  skip;
    int  n_items;
    int  ep;
    int  k;
    int  roll;
    int  pick;
    int  tot;
    int  last_ep;
    bit  drain;

    // directed: empty report, tail, done, duplicates, nothing, clamp, merge
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 0, 2, 0);
    queue_beat(CMD_REPORT, 4095, 8191, 0);
    queue_beat(CMD_DATA, 1, 2, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 1, 2, 0);
    queue_beat(CMD_DATA, 0, 0, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 2, 1, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 6, 0, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 4, 8191, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 9, 4096, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 3, 10, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 5, 10, 0);
    queue_beat(CMD_DATA, 7, 10, 0);
    queue_beat(CMD_DATA, 8, 10, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);
    queue_beat(CMD_DATA, 10, 11, 0);
    queue_beat(CMD_REPORT, 0, 0, 0);

    // random: windows of arrivals that climb toward the top block
    base    = 11;
    last_ep = 24;
    for (ep = 0; ep <= last_ep; ep++) begin
      if (ep == last_ep) begin
        w    = $urandom_range(4, 16);
        base = MAX_BLOCKS - w;
      end else begin
        w = $urandom_range(4, 24);
      end
      n_items = $urandom_range(7, 13);
      for (k = 0; k < n_items; k++) begin
        drain = (k == 0 && ep % 5 == 4);
        pick  = $urandom_range(0, 19);
        if (pick < 12)      tot = base + w;
        else if (pick < 19) tot = $urandom_range(0, MAX_BLOCKS);
        else                tot = $urandom_range(MAX_BLOCKS + 1, (1 << TOT_W) - 1);
        roll = $urandom_range(0, 99);
        if (roll < 20)
          queue_beat(CMD_REPORT, $urandom_range(0, MAX_BLOCKS - 1), tot, drain);
        else if (roll < 30)
          queue_beat(CMD_DATA, $urandom_range(0, base + w - 1), tot, drain);
        else
          queue_beat(CMD_DATA, base + $urandom_range(0, w - 1), tot, drain);
      end
      if (ep == last_ep) begin
        queue_beat(CMD_DATA, MAX_BLOCKS - 1, MAX_BLOCKS, 0);
        queue_beat(CMD_REPORT, 0, 0, 0);
      end else begin
        room = MAX_BLOCKS - 64 - base - w;
        if (room < 0) room = 0;
        skip = $urandom_range(0, 2 * room / (last_ep - ep));
        if (skip > room) skip = room;
        base = base + w + skip;
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (fail_count == 0 && answer_q.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
